[hdl/cv3_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cv3_pkg
// Shared types, constants and helpers for the 3x3 RGB convolution filter.
// ----------------------------------------------------------------------------
package cv3_pkg;

  // geometry defaults
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;

  // datapath widths
  localparam int PIX_W   = 24;   // packed R,G,B
  localparam int CH_W    = 8;
  localparam int COEF_W  = 16;   // signed Q8.8
  localparam int KROW_W  = 48;   // three coefficients
  localparam int DIV_W   = 16;
  localparam int OFF_W   = 9;
  localparam int SIZE_W  = 12;   // size registers
  localparam int CNT_W   = 16;   // row counters and extended sizes
  localparam int ACC_W   = 28;   // 9 * 255 * 32768 fits with sign
  localparam int MAG_W   = ACC_W - 1;
  localparam int LANES   = 3;
  localparam int CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KTOP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KMID    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KBOT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIVISOR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd6;

  // register reset values
  localparam logic [KROW_W-1:0] KTOP_RST    = 48'h0;
  localparam logic [KROW_W-1:0] KMID_RST    = 48'h0000_0100_0000;
  localparam logic [KROW_W-1:0] KBOT_RST    = 48'h0;
  localparam logic [DIV_W-1:0]  DIVISOR_RST = 16'd256;
  localparam logic [OFF_W-1:0]  OFFSET_RST  = 9'd0;
  localparam logic [SIZE_W-1:0] WIDTH_RST   = 12'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RST  = 12'd480;

  // last kernel row and column index
  localparam logic [1:0] TAP_LAST = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MAC,
    S_DIVL,
    S_DIV,
    S_OUT
  } state_e;

  // lane control, one strobe group per cycle
  typedef struct packed {
    logic mac_clr;
    logic mac_en;
    logic div_load;
    logic div_step;
  } lane_ctrl_t;

  // pick one coefficient out of a kernel row, left tap lowest
  function automatic logic signed [COEF_W-1:0] coef_sel(input logic [KROW_W-1:0] row,
                                                        input logic [1:0] c);
    logic signed [COEF_W-1:0] r;
    unique case (c)
      2'd0:    r = row[15:0];
      2'd1:    r = row[31:16];
      2'd2:    r = row[47:32];
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/cv3_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cv3_lane
// One colour channel: multiply-accumulate over the nine taps, then a
// restoring divide one bit a cycle, offset and clamp.
// ----------------------------------------------------------------------------
module cv3_lane
  import cv3_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire lane_ctrl_t               ctrl_i,
  input  wire logic [CH_W-1:0]          pix_i,
  input  wire logic signed [COEF_W-1:0] coef_i,
  input  wire logic [DIV_W-1:0]         divisor_i,  // never zero
  input  wire logic signed [OFF_W-1:0]  offset_i,
  output logic [CH_W-1:0]               res_o
);

  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [MAG_W-1:0]        dq_q, dq_d;     // dividend in, quotient out
  logic [DIV_W-1:0]        rem_q, rem_d;
  logic                    neg_q, neg_d;

  logic signed [CH_W+COEF_W:0] prod;
  logic [DIV_W:0]              rem_sh;
  logic signed [ACC_W-1:0]     qs;
  logic signed [ACC_W:0]       v;

  // tap product, pixel taken as unsigned
  assign prod   = $signed({1'b0, pix_i}) * coef_i;
  assign rem_sh = {rem_q, dq_q[MAG_W-1]};

  always_comb begin
    acc_d = acc_q;
    dq_d  = dq_q;
    rem_d = rem_q;
    neg_d = neg_q;
    if (ctrl_i.mac_clr) begin
      acc_d = '0;
    end else if (ctrl_i.mac_en) begin
      acc_d = acc_q + ACC_W'(prod);
    end
    if (ctrl_i.div_load) begin
      neg_d = acc_q[ACC_W-1];
      dq_d  = acc_q[ACC_W-1] ? MAG_W'(-acc_q) : acc_q[MAG_W-1:0];
      rem_d = '0;
    end else if (ctrl_i.div_step) begin
      if (rem_sh >= {1'b0, divisor_i}) begin
        rem_d = DIV_W'(rem_sh - {1'b0, divisor_i});
        dq_d  = {dq_q[MAG_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DIV_W-1:0];
        dq_d  = {dq_q[MAG_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      neg_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      neg_q <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
  end

  // sign back on, offset, clamp to 0..255
  assign qs = neg_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});
  assign v  = $signed({qs[ACC_W-1], qs}) + (ACC_W+1)'(offset_i);

  always_comb begin
    if (v < 0) begin
      res_o = '0;
    end else if (v > 255) begin
      res_o = '1;
    end else begin
      res_o = v[CH_W-1:0];
    end
  end

endmodule
`default_nettype wire

[hdl/cv3_out.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cv3_out
// Merges the three lane results into one output beat and holds it until
// the sink takes it.
// ----------------------------------------------------------------------------
module cv3_out
  import cv3_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire logic [CH_W-1:0]   red_i,
  input  wire logic [CH_W-1:0]   green_i,
  input  wire logic [CH_W-1:0]   blue_i,
  input  wire logic              last_i,
  output logic                   free_o,
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  output logic [PIX_W-1:0]       m_axis_tdata_o,   // red_out, green_out, blue_out
  output logic                   m_axis_tlast_o    // frame_end
);

  logic             valid_q, valid_d;
  logic [PIX_W-1:0] data_q;
  logic             last_q;

  assign free_o = !valid_q || m_axis_tready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, red in the low byte
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= {blue_i, green_i, red_i};
      last_q <= last_i;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tlast_o  = last_q;

endmodule
`default_nettype wire

[hdl/conv3x3_rgb_filter.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// conv3x3_rgb_filter
// Streaming 3x3 convolution of RGB pixels with two line stores, three
// channel lanes and a shared output stage.
// ----------------------------------------------------------------------------
// Channel   Dir  Beat contents
// s_axis    in   tdata red,green,blue; tuser op (1 = flush)
// m_axis    out  tdata red,green,blue; tlast frame_end
// cfg       in   write enable, register index, 48-bit data
//
// A beat that gives no output passes through the accept and line store read steps.
// A beat that gives an output then also passes through the nine
// multiply-accumulate taps per lane, the divider load, the bit-serial divider and the output step.
// The output register frees the input side while a result waits; a stalled
// sink holds the block only when the next result is ready.
// Reset clears counters, window and configuration registers; line stores are not cleared.
// ----------------------------------------------------------------------------
module conv3x3_rgb_filter
  import cv3_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  wire logic [PIX_W-1:0]     s_axis_tdata_i,   // red_in, green_in, blue_in
  input  wire logic                 s_axis_tuser_i,   // op
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  output logic [PIX_W-1:0]          m_axis_tdata_o,   // red_out, green_out, blue_out
  output logic                      m_axis_tlast_o,   // frame_end
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [KROW_W-1:0]    cfg_wdata_i
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  // configuration registers
  logic [KROW_W-1:0] ktop_q, kmid_q, kbot_q;
  logic [DIV_W-1:0]  divisor_q;
  logic [OFF_W-1:0]  offset_q;
  logic [SIZE_W-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ktop_q    <= KTOP_RST;
      kmid_q    <= KMID_RST;
      kbot_q    <= KBOT_RST;
      divisor_q <= DIVISOR_RST;
      offset_q  <= OFFSET_RST;
      width_q   <= WIDTH_RST;
      height_q  <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_KTOP:    ktop_q    <= cfg_wdata_i;
        REG_KMID:    kmid_q    <= cfg_wdata_i;
        REG_KBOT:    kbot_q    <= cfg_wdata_i;
        REG_DIVISOR: divisor_q <= cfg_wdata_i[DIV_W-1:0];
        REG_OFFSET:  offset_q  <= cfg_wdata_i[OFF_W-1:0];
        REG_WIDTH:   width_q   <= cfg_wdata_i[SIZE_W-1:0];
        REG_HEIGHT:  height_q  <= cfg_wdata_i[SIZE_W-1:0];
        default:     ;
      endcase
    end
  end

  // effective sizes and divisor
  logic [CNT_W-1:0] w_s, h_s;
  logic [DIV_W-1:0] div_s;

  always_comb begin
    w_s = CNT_W'(width_q);
    if (w_s == '0) w_s = CNT_W'(1);
    if (w_s > CNT_W'(MAX_WIDTH)) w_s = CNT_W'(MAX_WIDTH);
    h_s = CNT_W'(height_q);
    if (h_s == '0) h_s = CNT_W'(1);
    if (h_s > CNT_W'(MAX_HEIGHT)) h_s = CNT_W'(MAX_HEIGHT);
    div_s = (divisor_q == '0) ? DIV_W'(1) : divisor_q;
  end

  // state and counters
  state_e           state_q, state_d;
  logic [COL_W-1:0] icol_q, icol_d, col_q, col_d, ocol_q, ocol_d, ocw;
  logic [CNT_W-1:0] irow_q, irow_d, orow_q, orow_d;
  logic [PIX_W-1:0] pix_q, pix_d;
  logic             mt_q, mb_q, ml_q, mr_q, last_q;
  logic             mt_d, mb_d, ml_d, mr_d, last_d;
  logic [1:0]       tr_q, tr_d, tc_q, tc_d;
  logic [4:0]       dcnt_q, dcnt_d;
  logic             rd_en, wr_en, out_load, out_free, tap_on, emit;
  logic [COL_W-1:0] rd_addr;
  lane_ctrl_t       ctrl;

  // line stores
  logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
  logic [PIX_W-1:0] top_rd_q, mid_rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      upper_mem[col_q]  <= mid_rd_q;
      middle_mem[col_q] <= pix_q;
    end
    if (rd_en) begin
      top_rd_q <= upper_mem[rd_addr];
      mid_rd_q <= middle_mem[rd_addr];
    end
  end

  // 3x3 window, right column newest
  logic [PIX_W-1:0] win_q [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else if (state_q == S_READ) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r*3]   <= win_q[r*3+1];
        win_q[r*3+1] <= win_q[r*3+2];
      end
      win_q[2] <= top_rd_q;
      win_q[5] <= mid_rd_q;
      win_q[8] <= pix_q;
    end
  end

  assign rd_addr = (CNT_W'(icol_q) >= w_s) ? '0 : icol_q;
  assign emit    = (irow_q >= CNT_W'(2)) || ((irow_q == CNT_W'(1)) && (col_q != '0));
  assign ocw     = (CNT_W'(ocol_q) >= w_s) ? '0 : ocol_q;
  assign tap_on  = !((tr_q == 2'd0) && mt_q) && !((tr_q == TAP_LAST) && mb_q) &&
                   !((tc_q == 2'd0) && ml_q) && !((tc_q == TAP_LAST) && mr_q);

  // sequencer
  always_comb begin
    state_d  = state_q;
    icol_d   = icol_q;
    irow_d   = irow_q;
    ocol_d   = ocol_q;
    orow_d   = orow_q;
    col_d    = col_q;
    pix_d    = pix_q;
    mt_d     = mt_q;
    mb_d     = mb_q;
    ml_d     = ml_q;
    mr_d     = mr_q;
    last_d   = last_q;
    tr_d     = tr_q;
    tc_d     = tc_q;
    dcnt_d   = dcnt_q;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    out_load = 1'b0;
    ctrl     = '0;
    s_axis_tready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        // a flush counts only while draining, a pixel only before it
        if (s_axis_tvalid_i && (s_axis_tuser_i == (irow_q >= h_s))) begin
          col_d   = rd_addr;
          pix_d   = s_axis_tuser_i ? '0 : {s_axis_tdata_i[7:0], s_axis_tdata_i[15:8],
                                           s_axis_tdata_i[23:16]};
          rd_en   = 1'b1;
          state_d = S_READ;
        end
      end
      S_READ: begin
        wr_en = 1'b1;
        if (CNT_W'(col_q) + CNT_W'(1) >= w_s) begin
          icol_d = '0;
          if (irow_q != '1) irow_d = irow_q + CNT_W'(1);
        end else begin
          icol_d = col_q + COL_W'(1);
        end
        if (emit) begin
          mt_d   = (orow_q == '0);
          mb_d   = (orow_q + CNT_W'(1) >= h_s);
          ml_d   = (ocw == '0);
          mr_d   = (CNT_W'(ocw) + CNT_W'(1) >= w_s);
          last_d = mb_d && mr_d;
          if (last_d) begin
            icol_d = '0;
            irow_d = '0;
            ocol_d = '0;
            orow_d = '0;
          end else if (mr_d) begin
            ocol_d = '0;
            orow_d = orow_q + CNT_W'(1);
          end else begin
            ocol_d = ocw + COL_W'(1);
          end
          ctrl.mac_clr = 1'b1;
          tr_d    = '0;
          tc_d    = '0;
          state_d = S_MAC;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_MAC: begin
        ctrl.mac_en = tap_on;
        if (tc_q == TAP_LAST) begin
          tc_d = '0;
          tr_d = tr_q + 2'd1;
          if (tr_q == TAP_LAST) state_d = S_DIVL;
        end else begin
          tc_d = tc_q + 2'd1;
        end
      end
      S_DIVL: begin
        ctrl.div_load = 1'b1;
        dcnt_d  = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        ctrl.div_step = 1'b1;
        dcnt_d = dcnt_q + 5'd1;
        if (dcnt_q == 5'(MAG_W - 1)) state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      icol_q  <= '0;
      irow_q  <= '0;
      ocol_q  <= '0;
      orow_q  <= '0;
      tr_q    <= '0;
      tc_q    <= '0;
      dcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      icol_q  <= icol_d;
      irow_q  <= irow_d;
      ocol_q  <= ocol_d;
      orow_q  <= orow_d;
      tr_q    <= tr_d;
      tc_q    <= tc_d;
      dcnt_q  <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q  <= col_d;
    pix_q  <= pix_d;
    mt_q   <= mt_d;
    mb_q   <= mb_d;
    ml_q   <= ml_d;
    mr_q   <= mr_d;
    last_q <= last_d;
  end

  // tap selection shared by the lanes
  logic [PIX_W-1:0]         tap_pix;
  logic [KROW_W-1:0]        krow;
  logic signed [COEF_W-1:0] coef;

  assign tap_pix = win_q[4'(tr_q) * 4'd3 + 4'(tc_q)];

  always_comb begin
    unique case (tr_q)
      2'd0:    krow = ktop_q;
      2'd1:    krow = kmid_q;
      default: krow = kbot_q;
    endcase
  end

  assign coef = coef_sel(krow, tc_q);

  // channel lanes: red, green, blue
  logic [CH_W-1:0] res [LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    cv3_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .pix_i     (tap_pix[PIX_W-1-l*CH_W -: CH_W]),
      .coef_i    (coef),
      .divisor_i (div_s),
      .offset_i  ($signed(offset_q)),
      .res_o     (res[l])
    );
  end

  cv3_out u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (out_load),
    .red_i           (res[0]),
    .green_i         (res[1]),
    .blue_i          (res[2]),
    .last_i          (last_q),
    .free_o          (out_free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // checks
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == S_OUT))
    else $error("output beat raised outside the output step");

  a_tap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MAC) |-> (tr_q <= TAP_LAST) && (tc_q <= TAP_LAST))
    else $error("kernel tap index out of range");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) && $past(state_q == S_DIV) |-> $past(dcnt_q == 5'(MAG_W - 1)))
    else $error("divider left before all quotient bits");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled output beat changed");

endmodule
`default_nettype wire
